// File: src/sdlc_pkg.sv
`timescale 1ns / 1ps

package sdlc_pkg;

	localparam int MAX_CHUNKS   = 16;
	localparam int NUM_DISKS    = 1024;
	localparam int STRIPE_DEPTH = 4096;

	localparam int POS_W    = $clog2(MAX_CHUNKS);
	localparam int DISK_W   = $clog2(NUM_DISKS);
	localparam int STRIPE_W = $clog2(STRIPE_DEPTH);
	localparam int LOC_AW   = STRIPE_W + POS_W;
	localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);

	localparam int CFG_W    = 5;
	localparam int SCNT_W   = 13;
	localparam int CCNT_W   = 16;
	localparam int LIMIT_W  = 7;
	localparam int GRP_W    = 3;
	localparam int GLOB_W   = 2;

	localparam logic [SCNT_W-1:0] STRIPE_CNT_MAX = '1;
	localparam logic [CCNT_W-1:0] CHUNK_CNT_MAX  = '1;

	localparam logic [POS_W-1:0] LRC_LOCAL0  = POS_W'(6);
	localparam logic [POS_W-1:0] LRC_LOCAL1  = POS_W'(14);
	localparam logic [POS_W-1:0] LRC_GLOBAL0 = POS_W'(7);
	localparam logic [POS_W-1:0] LRC_GLOBAL1 = POS_W'(15);
	localparam logic [POS_W-1:0] LRC_GROUP_POS [2][6] = '{
		'{POS_W'(0), POS_W'(1), POS_W'(2), POS_W'(3), POS_W'(4), POS_W'(5)},
		'{POS_W'(8), POS_W'(9), POS_W'(10), POS_W'(11), POS_W'(12), POS_W'(13)}
	};

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_SET_DISK = 2'd1,
		OP_CHECK    = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_CODE_WIDTH   = 2'd0,
		CFG_CODE_DATA    = 2'd1,
		CFG_LOCAL_GROUPS = 2'd2,
		CFG_USE_LRC      = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_RUN   = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

endpackage

// File: src/stripe_data_loss_checker_top.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in        in_valid / in_stall   op, stripe, chunk_pos, disk, disk_failed
// out       out_valid / out_stall stripe_lost, failed_chunks, lost_stripe_total,
//                                 lost_chunk_total, any_loss
// cfg       cfg_we                cfg_index, cfg_wdata
//
// Loads, disk state changes and clears complete as they are taken, and the next item
// may follow straight after. A check reads one location per chunk, streams each
// through the failure map read, then drains the pipeline and updates the totals
// as its result is registered; no other item is taken until that result is registered.
// After reset the failure map is cleared one disk a cycle, so no item is taken
// until all 1024 disks are cleared; configuration writes are taken throughout.
// A finished result waits in the output register while out_stall is high; further
// items are still taken meanwhile, and a check then holds in its last step.

module stripe_data_loss_checker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [sdlc_pkg::STRIPE_W-1:0]   stripe,
	input  logic [sdlc_pkg::POS_W-1:0]      chunk_pos,
	input  logic [sdlc_pkg::DISK_W-1:0]     disk,
	input  logic                            disk_failed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            stripe_lost,
	output logic [sdlc_pkg::CNT_W-1:0]      failed_chunks,
	output logic [sdlc_pkg::SCNT_W-1:0]     lost_stripe_total,
	output logic [sdlc_pkg::CCNT_W-1:0]     lost_chunk_total,
	output logic                            any_loss,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [sdlc_pkg::CFG_W-1:0]      cfg_wdata
);

	sdlc_pkg::state_t state_q, state_d;

	logic [4:0] code_width_q;
	logic [3:0] code_data_q;
	logic [1:0] local_groups_q;
	logic       use_lrc_q;

	logic [sdlc_pkg::DISK_W-1:0] loc_mem [2**sdlc_pkg::LOC_AW];
	logic                        fmap_mem [sdlc_pkg::NUM_DISKS];

	logic [sdlc_pkg::DISK_W-1:0]   clr_idx_q;
	logic [sdlc_pkg::STRIPE_W-1:0] stripe_q;
	logic [sdlc_pkg::CNT_W-1:0]    n_q;
	logic [sdlc_pkg::CNT_W-1:0]    iss_q;

	logic [sdlc_pkg::DISK_W-1:0] loc_rdata_s1;
	logic                        valid_s1;
	logic [sdlc_pkg::POS_W-1:0]  pos_s1;
	logic                        bad_s2;
	logic                        valid_s2;
	logic [sdlc_pkg::POS_W-1:0]  pos_s2;

	logic [sdlc_pkg::CNT_W-1:0]  fail_q;
	logic [sdlc_pkg::GRP_W-1:0]  grp_q [2];
	logic [sdlc_pkg::GLOB_W-1:0] glob_q;

	logic [sdlc_pkg::SCNT_W-1:0] scnt_q;
	logic [sdlc_pkg::CCNT_W-1:0] ccnt_q;
	logic                        seen_q;

	logic                        out_valid_q;
	logic                        lost_q;
	logic [sdlc_pkg::CNT_W-1:0]  failed_out_q;
	logic [sdlc_pkg::SCNT_W-1:0] scnt_out_q;
	logic [sdlc_pkg::CCNT_W-1:0] ccnt_out_q;
	logic                        seen_out_q;

	logic                        accept;
	logic                        issue;
	logic                        fire;
	logic                        clearing;
	logic                        pipe_empty;
	logic [1:0]                  l_eff;
	logic [sdlc_pkg::CNT_W-1:0]  n_eff;
	logic [sdlc_pkg::LOC_AW-1:0] loc_raddr;
	logic [sdlc_pkg::LOC_AW-1:0] loc_waddr;
	logic                        loc_we;
	logic                        fm_we;
	logic [sdlc_pkg::DISK_W-1:0] fm_waddr;
	logic                        fm_wdata;
	logic [sdlc_pkg::CNT_W-1:0]  sum_u;
	logic signed [sdlc_pkg::LIMIT_W-1:0] sum_s;
	logic signed [sdlc_pkg::LIMIT_W-1:0] limit_s;
	logic                        lost_d;
	logic [sdlc_pkg::SCNT_W-1:0] scnt_d;
	logic [sdlc_pkg::CCNT_W:0]   csum;
	logic [sdlc_pkg::CCNT_W-1:0] ccnt_d;
	logic                        in_group [2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_width_q   <= 5'd16;
			code_data_q    <= 4'd12;
			local_groups_q <= 2'd2;
			use_lrc_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (sdlc_pkg::cfg_index_t'(cfg_index))
				sdlc_pkg::CFG_CODE_WIDTH:   code_width_q   <= cfg_wdata[4:0];
				sdlc_pkg::CFG_CODE_DATA:    code_data_q    <= cfg_wdata[3:0];
				sdlc_pkg::CFG_LOCAL_GROUPS: local_groups_q <= cfg_wdata[1:0];
				sdlc_pkg::CFG_USE_LRC:      use_lrc_q      <= cfg_wdata[0];
			endcase
		end
	end

	assign l_eff = (local_groups_q > 2'd2) ? 2'd2 : local_groups_q;
	assign n_eff = (code_width_q > 5'(sdlc_pkg::MAX_CHUNKS)) ?
		sdlc_pkg::CNT_W'(sdlc_pkg::MAX_CHUNKS) : sdlc_pkg::CNT_W'(code_width_q);

	assign pipe_empty = !valid_s1 && !valid_s2;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdlc_pkg::ST_CLEAR: begin
				if (clr_idx_q == sdlc_pkg::DISK_W'(sdlc_pkg::NUM_DISKS - 1))
					state_d = sdlc_pkg::ST_IDLE;
			end
			sdlc_pkg::ST_IDLE: begin
				if (in_valid && sdlc_pkg::op_t'(op) == sdlc_pkg::OP_CHECK)
					state_d = sdlc_pkg::ST_RUN;
			end
			sdlc_pkg::ST_RUN: begin
				if (iss_q == n_q && pipe_empty)
					state_d = sdlc_pkg::ST_DONE;
			end
			sdlc_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = sdlc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall = 1'b1;
		clearing = 1'b0;
		issue    = 1'b0;
		fire     = 1'b0;
		unique case (state_q)
			sdlc_pkg::ST_CLEAR: clearing = 1'b1;
			sdlc_pkg::ST_IDLE:  in_stall = 1'b0;
			sdlc_pkg::ST_RUN:   issue    = (iss_q < n_q);
			sdlc_pkg::ST_DONE:  fire     = !out_valid_q || !out_stall;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sdlc_pkg::ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// Location memory.
	assign loc_we    = accept && sdlc_pkg::op_t'(op) == sdlc_pkg::OP_LOAD;
	assign loc_waddr = {stripe, chunk_pos};
	assign loc_raddr = {stripe_q, iss_q[sdlc_pkg::POS_W-1:0]};

	always_ff @(posedge clk) begin
		if (loc_we)
			loc_mem[loc_waddr] <= disk;
		loc_rdata_s1 <= loc_mem[loc_raddr];
	end

	// Failure map memory.
	assign fm_we    = clearing || (accept && sdlc_pkg::op_t'(op) == sdlc_pkg::OP_SET_DISK);
	assign fm_waddr = clearing ? clr_idx_q : disk;
	assign fm_wdata = clearing ? 1'b0 : disk_failed;

	always_ff @(posedge clk) begin
		if (fm_we)
			fmap_mem[fm_waddr] <= fm_wdata;
		bad_s2 <= fmap_mem[loc_rdata_s1];
	end

	always_ff @(posedge clk) begin
		pos_s1 <= iss_q[sdlc_pkg::POS_W-1:0];
		pos_s2 <= pos_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && sdlc_pkg::op_t'(op) == sdlc_pkg::OP_CHECK) begin
			stripe_q <= stripe;
			n_q      <= n_eff;
		end
	end

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			in_group[g] = 1'b0;
			for (int j = 0; j < 6; j++)
				if (pos_s2 == sdlc_pkg::LRC_GROUP_POS[g][j])
					in_group[g] = 1'b1;
			if (2'(g) >= l_eff)
				in_group[g] = 1'b0;
		end
	end

	// Chunk walk: issue counter and failure tallies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q    <= '0;
			fail_q   <= '0;
			glob_q   <= '0;
			grp_q[0] <= '0;
			grp_q[1] <= '0;
		end else if (accept && sdlc_pkg::op_t'(op) == sdlc_pkg::OP_CHECK) begin
			iss_q    <= '0;
			fail_q   <= '0;
			glob_q   <= '0;
			grp_q[0] <= '0;
			grp_q[1] <= '0;
		end else begin
			if (issue)
				iss_q <= iss_q + 1'b1;
			if (valid_s2) begin
				if (bad_s2) begin
					fail_q <= fail_q + 1'b1;
					if (pos_s2 == sdlc_pkg::LRC_GLOBAL0 || pos_s2 == sdlc_pkg::LRC_GLOBAL1)
						glob_q <= glob_q + 1'b1;
					else if (in_group[0])
						grp_q[0] <= grp_q[0] + 1'b1;
					else if (in_group[1])
						grp_q[1] <= grp_q[1] + 1'b1;
				end else begin
					if (pos_s2 == sdlc_pkg::LRC_LOCAL0 && l_eff >= 2'd1 && grp_q[0] != '0)
						grp_q[0] <= grp_q[0] - 1'b1;
					if (pos_s2 == sdlc_pkg::LRC_LOCAL1 && l_eff >= 2'd2 && grp_q[1] != '0)
						grp_q[1] <= grp_q[1] - 1'b1;
				end
			end
		end
	end

	// Loss decision and saturating totals.
	always_comb begin
		if (use_lrc_q) begin
			sum_u   = sdlc_pkg::CNT_W'(glob_q) + sdlc_pkg::CNT_W'(grp_q[0])
				+ sdlc_pkg::CNT_W'(grp_q[1]);
			limit_s = $signed({2'b00, code_width_q}) - $signed({3'b000, code_data_q})
				- $signed({5'b00000, l_eff});
		end else begin
			sum_u   = fail_q;
			limit_s = $signed({2'b00, code_width_q}) - $signed({3'b000, code_data_q});
		end
		sum_s  = $signed({2'b00, sum_u});
		lost_d = (fail_q != '0) && (sum_s > limit_s);
		scnt_d = scnt_q;
		ccnt_d = ccnt_q;
		csum   = {1'b0, ccnt_q} + (sdlc_pkg::CCNT_W + 1)'(fail_q);
		if (lost_d) begin
			if (scnt_q != sdlc_pkg::STRIPE_CNT_MAX)
				scnt_d = scnt_q + 1'b1;
			ccnt_d = csum[sdlc_pkg::CCNT_W] ? sdlc_pkg::CHUNK_CNT_MAX
				: csum[sdlc_pkg::CCNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
			ccnt_q <= '0;
			seen_q <= 1'b0;
		end else if (accept && sdlc_pkg::op_t'(op) == sdlc_pkg::OP_CLEAR) begin
			scnt_q <= '0;
			ccnt_q <= '0;
			seen_q <= 1'b0;
		end else if (fire) begin
			scnt_q <= scnt_d;
			ccnt_q <= ccnt_d;
			seen_q <= seen_q || lost_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			lost_q       <= lost_d;
			failed_out_q <= fail_q;
			scnt_out_q   <= scnt_d;
			ccnt_out_q   <= ccnt_d;
			seen_out_q   <= seen_q || lost_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign stripe_lost       = lost_q;
	assign failed_chunks     = failed_out_q;
	assign lost_stripe_total = scnt_out_q;
	assign lost_chunk_total  = ccnt_out_q;
	assign any_loss          = seen_out_q;

	a_issue_bound : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sdlc_pkg::ST_RUN |-> iss_q <= n_q)
		else $error("chunk issue counter ran past the stripe width");

	a_fail_bound : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sdlc_pkg::ST_DONE |-> fail_q <= n_q)
		else $error("more failed chunks than chunks read");

	a_lost_consistent : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stripe_lost |-> failed_chunks != '0 && any_loss)
		else $error("lost stripe reported without failed chunks or loss flag");

endmodule
